/* src/cbtc_pkg.sv */
// ============================================================================
// cbtc_pkg
// Shared types, constants and the cosine table generator for the cosine-basis
// trajectory coefficient core.
// ============================================================================
package cbtc_pkg;

    // Field widths
    localparam int POS_W      = 16;
    localparam int WAVE_W     = 8;
    localparam int SCALE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int COEF_W     = 48;
    localparam int PHASE_W    = 17;
    localparam int COS_W      = 16;
    localparam int ACC_W      = 34;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_Z     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_SCALE = 2'd2;

    // Register reset values
    localparam logic [WAVE_W-1:0]  WAVE_RESET  = 8'd0;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

    // Accumulator limits, one guard bit beyond the 34-bit sum plus carry
    localparam logic signed [ACC_W+1:0] ACC_HI = 36'sd8589934591;
    localparam logic signed [ACC_W+1:0] ACC_LO = -36'sd8589934592;

    // Result magnitude limits (48-bit signed)
    localparam logic [49:0] OUT_POS_LIM = 50'd140737488355327;
    localparam logic [49:0] OUT_NEG_LIM = 50'd140737488355328;

    // Rounding constants
    localparam logic signed [31:0] PROD_HALF  = 32'sd16384;
    localparam logic [64:0]        SCALE_HALF = 65'd65536;

    // Cosine table generation constants (Q30)
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] COS_MAX     = 64'd32767;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE,
        ST_RD_X,
        ST_RD_Z,
        ST_MUL,
        ST_ACC,
        ST_MAG,
        ST_SCALE,
        ST_EMIT
    } cbtc_state_t;

    // Datapath commands, at most one per cycle
    typedef struct packed {
        logic load;
        logic phase;
        logic rd_x;
        logic rd_z;
        logic mul;
        logic acc;
        logic mag;
        logic scale;
        logic emit;
    } cbtc_cmd_t;

    // Datapath status
    typedef struct packed {
        logic last;
    } cbtc_stat_t;

    // One Taylor step of the cosine series: r = 1 - x*r / den, floored at 0
    function automatic logic [63:0] taylor_clip(input logic [63:0] term);
        return (term > Q30_ONE) ? 64'd0 : Q30_ONE - term;
    endfunction

    // Cosine of angle t (Q30 radians) in Q1.15, elaboration-time only
    function automatic logic [COS_W-1:0] cos_taylor(input logic [63:0] t);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] q;
        x = (t * t) >> 30;
        r = Q30_ONE;
        r = taylor_clip(((x * r) >> 30) / 64'd182);
        r = taylor_clip(((x * r) >> 30) / 64'd132);
        r = taylor_clip(((x * r) >> 30) / 64'd90);
        r = taylor_clip(((x * r) >> 30) / 64'd56);
        r = taylor_clip(((x * r) >> 30) / 64'd30);
        r = taylor_clip(((x * r) >> 30) / 64'd12);
        r = taylor_clip(((x * r) >> 30) / 64'd2);
        q = (r + 64'd16384) >> 15;
        if (q > COS_MAX)
        begin
            q = COS_MAX;
        end
        return q[COS_W-1:0];
    endfunction

endpackage

/* src/cbtc_sample_if.sv */
// ============================================================================
// cbtc_sample_if
// Sample channel: one trajectory point per beat, with end-of-trajectory mark.
// ============================================================================
interface cbtc_sample_if;
    import cbtc_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_z;
    logic             last_sample;

    modport source (output valid, output pos_x, output pos_z, output last_sample,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_z, input last_sample,
                    output ready);
endinterface

/* src/cbtc_result_if.sv */
// ============================================================================
// cbtc_result_if
// Result channel: one coefficient per beat with its saturation flag.
// ============================================================================
interface cbtc_result_if;
    import cbtc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coefficient;
    logic                     saturated;

    modport source (output valid, output coefficient, output saturated, input ready);
    modport sink   (input valid, input coefficient, input saturated, output ready);
endinterface

/* src/cbtc_cfg_if.sv */
// ============================================================================
// cbtc_cfg_if
// Configuration write channel: register index and write data per beat.
// ============================================================================
interface cbtc_cfg_if;
    import cbtc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/cbtc_ctrl.sv */
// ============================================================================
// cbtc_ctrl
// Sequencer for one sample: phase, two cosine reads, product, accumulate, and
// on the last sample magnitude, scale and result hand-off.
// ============================================================================
module cbtc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  cbtc_pkg::cbtc_stat_t stat,
    output cbtc_pkg::cbtc_cmd_t  cmd
);
    import cbtc_pkg::*;

    cbtc_state_t state_reg;
    cbtc_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    // Result register can take a new beat
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_PHASE;
            ST_PHASE: state_next = ST_RD_X;
            ST_RD_X:  state_next = ST_RD_Z;
            ST_RD_Z:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = stat.last ? ST_MAG : ST_IDLE;
            ST_MAG:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PHASE: cmd.phase = 1'b1;
            ST_RD_X:  cmd.rd_x  = 1'b1;
            ST_RD_Z:  cmd.rd_z  = 1'b1;
            ST_MUL:   cmd.mul   = 1'b1;
            ST_ACC:   cmd.acc   = 1'b1;
            ST_MAG:   cmd.mag   = 1'b1;
            ST_SCALE: cmd.scale = 1'b1;
            ST_EMIT:  cmd.emit  = out_free;
            default:  cmd = '0;
        endcase
    end

    // Hold the result beat until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

/* src/cbtc_dp.sv */
// ============================================================================
// cbtc_dp
// Datapath: configuration registers, phase multipliers, quarter-wave cosine
// ROM, basis product, trapezoid accumulator and the scaled result register.
// ============================================================================
module cbtc_dp #(
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  cbtc_pkg::cbtc_cmd_t                      cmd,
    output cbtc_pkg::cbtc_stat_t                     stat,
    input  logic                                     cfg_valid,
    input  logic [cbtc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [cbtc_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic [cbtc_pkg::POS_W-1:0]               pos_x,
    input  logic [cbtc_pkg::POS_W-1:0]               pos_z,
    input  logic                                     last_sample,
    output logic signed [cbtc_pkg::COEF_W-1:0]       coefficient,
    output logic                                     saturated
);
    import cbtc_pkg::*;

    localparam int IW = $clog2(COS_TABLE_DEPTH);
    localparam int JW = IW + 1;
    localparam int PW = 15 + JW;
    localparam logic [JW-1:0] DEPTH_J = JW'(COS_TABLE_DEPTH);

    // Configuration registers
    logic [WAVE_W-1:0]  wave_x_reg;
    logic [WAVE_W-1:0]  wave_z_reg;
    logic [SCALE_W-1:0] norm_scale_reg;

    // Sample and pipeline registers
    logic [POS_W-1:0]        pos_x_reg;
    logic [POS_W-1:0]        pos_z_reg;
    logic                    last_reg;
    logic [PHASE_W-1:0]      phase_x_reg;
    logic [PHASE_W-1:0]      phase_z_reg;
    logic [COS_W-1:0]        rom_q_reg;
    logic                    rneg_reg;
    logic                    rzero_reg;
    logic signed [COS_W-1:0] cx_reg;
    logic signed [31:0]      prod_reg;

    // Trajectory state
    logic signed [COS_W-1:0] prev_reg;
    logic signed [ACC_W-1:0] sum_reg;
    logic                    first_reg;
    logic                    sat_reg;

    // Result stage
    logic                    neg_reg;
    logic [ACC_W-1:0]        mag_reg;
    logic [63:0]             lo_prod_reg;
    logic [ACC_W-1:0]        hi_prod_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic                    saturated_reg;

    // Cosine table, one entry per quarter-wave step
    logic [COS_W-1:0] cos_rom [COS_TABLE_DEPTH];

    for (genvar g = 0; g < COS_TABLE_DEPTH; g++)
    begin : g_rom
        assign cos_rom[g] = cos_taylor(64'(g) * PI_HALF_Q30 / COS_TABLE_DEPTH);
    end

    // Load configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_x_reg     <= WAVE_RESET;
            wave_z_reg     <= WAVE_RESET;
            norm_scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WAVE_X:     wave_x_reg     <= cfg_data[WAVE_W-1:0];
                REG_WAVE_Z:     wave_z_reg     <= cfg_data[WAVE_W-1:0];
                REG_NORM_SCALE: norm_scale_reg <= cfg_data[SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Map phase to a table address with quadrant sign and zero flags
    logic [PHASE_W-1:0] phase_sel;
    logic [PW-1:0]      idx_prod;
    logic [JW-1:0]      idx_j;
    logic [JW-1:0]      rom_j;
    logic               rom_zero;
    logic               rom_neg;
    logic [IW-1:0]      rom_addr;

    always_comb
    begin
        phase_sel = cmd.rd_z ? phase_z_reg : phase_x_reg;
        idx_prod  = PW'(phase_sel[14:0]) * PW'(COS_TABLE_DEPTH);
        idx_j     = idx_prod[PW-1:15];
        rom_j     = phase_sel[15] ? DEPTH_J - idx_j : idx_j;
        rom_zero  = (rom_j >= DEPTH_J);
        rom_neg   = phase_sel[16] ^ phase_sel[15];
        rom_addr  = rom_zero ? '0 : rom_j[IW-1:0];
    end

    // Signed cosine from the registered table read
    logic signed [COS_W-1:0] cos_val;

    always_comb
    begin
        if (rzero_reg)
        begin
            cos_val = '0;
        end
        else if (rneg_reg)
        begin
            cos_val = -$signed(rom_q_reg);
        end
        else
        begin
            cos_val = $signed(rom_q_reg);
        end
    end

    // Round the product to Q1.15 and add the neighbor pair into the sum
    logic signed [31:0]      prod_rnd;
    logic signed [COS_W-1:0] p_val;
    logic signed [ACC_W+1:0] acc_raw;
    logic signed [ACC_W-1:0] acc_sat;
    logic                    acc_hit;

    always_comb
    begin
        prod_rnd = prod_reg + PROD_HALF;
        p_val    = COS_W'(prod_rnd >>> 15);
        acc_raw  = (ACC_W+2)'(sum_reg) + (ACC_W+2)'(prev_reg) + (ACC_W+2)'(p_val);
        acc_hit  = 1'b0;
        if (acc_raw > ACC_HI)
        begin
            acc_sat = ACC_W'(ACC_HI);
            acc_hit = 1'b1;
        end
        else if (acc_raw < ACC_LO)
        begin
            acc_sat = ACC_W'(ACC_LO);
            acc_hit = 1'b1;
        end
        else
        begin
            acc_sat = ACC_W'(acc_raw);
        end
    end

    // Magnitude of the sum
    logic signed [ACC_W:0] sum_ext;
    logic [ACC_W:0]        mag_w;

    always_comb
    begin
        sum_ext = (ACC_W+1)'(sum_reg);
        mag_w   = sum_reg[ACC_W-1] ? (ACC_W+1)'(-sum_ext) : (ACC_W+1)'(sum_ext);
    end

    // Combine partial products, round, clamp and restore sign
    logic [64:0]        lo_rnd;
    logic [49:0]        val_raw;
    logic [49:0]        val_lim;
    logic               res_hit;
    logic [COEF_W-1:0]  coef_w;

    always_comb
    begin
        lo_rnd  = 65'(lo_prod_reg) + SCALE_HALF;
        val_raw = 50'({hi_prod_reg, 15'b0}) + 50'(lo_rnd[64:17]);
        val_lim = val_raw;
        res_hit = 1'b0;
        if (!neg_reg && val_raw > OUT_POS_LIM)
        begin
            val_lim = OUT_POS_LIM;
            res_hit = 1'b1;
        end
        else if (neg_reg && val_raw > OUT_NEG_LIM)
        begin
            val_lim = OUT_NEG_LIM;
            res_hit = 1'b1;
        end
        coef_w = neg_reg ? COEF_W'(-val_lim) : COEF_W'(val_lim);
    end

    // Payload and pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_x_reg <= pos_x;
            pos_z_reg <= pos_z;
            last_reg  <= last_sample;
        end
        if (cmd.phase)
        begin
            phase_x_reg <= PHASE_W'(24'(wave_x_reg) * 24'(pos_x_reg));
            phase_z_reg <= PHASE_W'(24'(wave_z_reg) * 24'(pos_z_reg));
        end
        if (cmd.rd_x || cmd.rd_z)
        begin
            rom_q_reg <= cos_rom[rom_addr];
            rneg_reg  <= rom_neg;
            rzero_reg <= rom_zero;
        end
        if (cmd.rd_z)
        begin
            cx_reg <= cos_val;
        end
        if (cmd.mul)
        begin
            prod_reg <= 32'(cx_reg) * 32'(cos_val);
        end
        if (cmd.mag)
        begin
            neg_reg <= sum_reg[ACC_W-1];
            mag_reg <= mag_w[ACC_W-1:0];
        end
        // Upper two magnitude bits scale by shift and add
        if (cmd.scale)
        begin
            lo_prod_reg <= 64'(mag_reg[31:0]) * 64'(norm_scale_reg);
            hi_prod_reg <= (mag_reg[ACC_W-1] ? ACC_W'({norm_scale_reg, 1'b0}) : ACC_W'(0))
                         + (mag_reg[32] ? ACC_W'(norm_scale_reg) : ACC_W'(0));
        end
        if (cmd.emit)
        begin
            coef_reg      <= coef_w;
            saturated_reg <= sat_reg || res_hit;
        end
    end

    // Trajectory state: accumulate per sample, clear after the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            sum_reg   <= '0;
            first_reg <= 1'b1;
            sat_reg   <= 1'b0;
        end
        else if (cmd.acc)
        begin
            if (!first_reg)
            begin
                sum_reg <= acc_sat;
                if (acc_hit)
                begin
                    sat_reg <= 1'b1;
                end
            end
            prev_reg  <= p_val;
            first_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            prev_reg  <= '0;
            sum_reg   <= '0;
            first_reg <= 1'b1;
            sat_reg   <= 1'b0;
        end
    end

    assign stat.last   = last_reg;
    assign coefficient = coef_reg;
    assign saturated   = saturated_reg;
endmodule

/* src/cosine_basis_trajectory_coefficient_core.sv */
// ============================================================================
// cosine_basis_trajectory_coefficient_core
// Cosine-basis coefficient of a 2D trajectory: trapezoid sum of
// cos(kx*pi*x)*cos(kz*pi*z) over the samples, scaled and saturated to 48 bits.
//
//   channel  dir  beat carries
//   -------  ---  ---------------------------------------------
//   sample   in   pos_x, pos_z, last_sample
//   result   out  coefficient, saturated (one per trajectory)
//   cfg      in   index, data (wave_index_x, wave_index_z, norm_scale)
//
// A sample that is not last passes from its beat to the next accepted beat
// through phase, one cosine ROM read per axis on the single ROM port,
// product and accumulate. A last sample adds magnitude, 32x32 scale multiply
// and result load; the load waits while the result register waits on ready.
// Reset clears the trajectory state and sets wave indexes to 0, scale to 1.0.
// cfg is always ready; a new sample is taken while a result is still waiting.
// ============================================================================
module cosine_basis_trajectory_coefficient_core #(
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    cbtc_sample_if.sink    sample,
    cbtc_result_if.source  result,
    cbtc_cfg_if.sink       cfg
);
    import cbtc_pkg::*;

    cbtc_cmd_t  cmd;
    cbtc_stat_t stat;

    // Configuration writes are always accepted and take effect the next cycle
    assign cfg.ready = 1'b1;

    cbtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    cbtc_dp #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .pos_x       (sample.pos_x),
        .pos_z       (sample.pos_z),
        .last_sample (sample.last_sample),
        .coefficient (result.coefficient),
        .saturated   (result.saturated)
    );

`ifndef NO_ASSERTIONS
    // Sequencer issues at most one datapath step per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.phase, cmd.rd_x, cmd.rd_z, cmd.mul,
                  cmd.acc, cmd.mag, cmd.scale, cmd.emit}))
        else $error("more than one datapath command in a cycle");

    // Never overwrite a result beat that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!result.valid || result.ready))
        else $error("result overwritten while pending");

    // An accepted sample starts the phase step next cycle
    a_beat_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> cmd.phase)
        else $error("accepted sample did not start processing");

    // A loaded result is offered next cycle
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> result.valid)
        else $error("result not offered after load");
`endif
endmodule

/* tb/tb_cosine_basis_trajectory_coefficient_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_cosine_basis_trajectory_coefficient_core
// Self-checking bench for the cosine-basis trajectory coefficient core.
// Streams trajectories of sample pairs into the core and predicts each
// coefficient with a bit-exact model of the cosine table, the trapezoid sum
// and the output scaling. Covers directed corner cases, two long
// trajectories that build large sums at full scale,
// and random trajectories under several source/sink pacing phases.
// ============================================================================
module tb_cosine_basis_trajectory_coefficient_core;
    import cbtc_pkg::*;

    localparam int TABLE_DEPTH    = 1024;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_HEAVY     = 78;
    localparam int IDLE_LIGHT     = 27;
    localparam int SETTLE_CYCLES  = 16;
    localparam int ITEMS_PER_SET  = 90;
    localparam int SETS_PER_PHASE = 5;

    // Index that maps to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Trapezoid sum and output limits
    localparam longint    SUM_MAX   = 64'sd8589934591;
    localparam longint    SUM_MIN   = -64'sd8589934592;
    localparam bit [64:0] COEF_POS  = 65'd140737488355327;
    localparam bit [64:0] COEF_NEG  = 65'd140737488355328;
    localparam bit [31:0] SCALE_MAX = 32'hFFFF_FFFF;
    localparam bit [31:0] SCALE_ONE = 32'd65536;

    typedef struct {
        logic signed [COEF_W-1:0] coef;
        logic                     sat;
    } coef_result_t;

    // ------------------------------------------------------------------------
    // Coefficient predictor and result scoreboard
    // ------------------------------------------------------------------------
    class coef_scoreboard;
        int           cos_rom [TABLE_DEPTH];
        bit [7:0]     wave_x;
        bit [7:0]     wave_z;
        bit [31:0]    scale;
        int           prev_prod;
        longint       trap_sum;
        bit           first_pending;
        bit           sat_seen;
        coef_result_t expected_q [$];
        int           fails;
        int           checked;
        int           samples;
        int           saturated_seen;

        function new();
            longint unsigned t;
            longint unsigned x;
            longint unsigned r;
            longint unsigned term;
            longint unsigned q;
            // Quarter-wave table: Taylor series in Q30, rounded into Q1.15
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                t = (64'(i) * 64'd1686629713) / TABLE_DEPTH;
                x = (t * t) >> 30;
                r = 64'd1073741824;
                for (int n = 7; n >= 1; n--)
                begin
                    term = ((x * r) >> 30) / 64'((2 * n) * (2 * n - 1));
                    r = (term > 64'd1073741824) ? 64'd0 : 64'd1073741824 - term;
                end
                q = (r + 64'd16384) >> 15;
                if (q > 64'd32767)
                begin
                    q = 64'd32767;
                end
                cos_rom[i] = int'(q);
            end
            wave_x = WAVE_RESET;
            wave_z = WAVE_RESET;
            scale  = SCALE_RESET;
            fails = 0;
            checked = 0;
            samples = 0;
            saturated_seen = 0;
            clear_trajectory();
        endfunction

        function void clear_trajectory();
            prev_prod     = 0;
            trap_sum      = 0;
            first_pending = 1'b1;
            sat_seen      = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WAVE_X:     wave_x = data[7:0];
                REG_WAVE_Z:     wave_z = data[7:0];
                REG_NORM_SCALE: scale  = data;
                default:        ;
            endcase
        endfunction

        function int rom_at(int j);
            return (j >= TABLE_DEPTH) ? 0 : cos_rom[j];
        endfunction

        // cos(k*pi*pos) in Q1.15; phase wraps at one full turn (2^17)
        function int basis_cos(bit [7:0] k, bit [15:0] pos);
            bit [23:0] full;
            bit [16:0] phase;
            int        idx;
            full  = k * pos;
            phase = full[16:0];
            idx   = (int'(phase[14:0]) * TABLE_DEPTH) >> 15;
            case (phase[16:15])
                2'd0:    return rom_at(idx);
                2'd1:    return -rom_at(TABLE_DEPTH - idx);
                2'd2:    return -rom_at(idx);
                default: return rom_at(TABLE_DEPTH - idx);
            endcase
        endfunction

        // Advance the trajectory by one accepted sample
        function void note_sample(bit [15:0] px, bit [15:0] pz, bit last);
            int              p;
            longint          s;
            bit              neg;
            bit              res_sat;
            longint unsigned mag;
            longint unsigned hi;
            longint unsigned lo;
            bit [64:0]       hi_part;
            bit [64:0]       lo_part;
            bit [64:0]       val;
            coef_result_t    r;
            samples++;
            p = (basis_cos(wave_x, px) * basis_cos(wave_z, pz) + 16384) >>> 15;
            if (!first_pending)
            begin
                s = trap_sum + prev_prod + p;
                if (s > SUM_MAX)
                begin
                    s = SUM_MAX;
                    sat_seen = 1'b1;
                end
                if (s < SUM_MIN)
                begin
                    s = SUM_MIN;
                    sat_seen = 1'b1;
                end
                trap_sum = s;
            end
            prev_prod = p;
            first_pending = 1'b0;
            if (!last)
            begin
                return;
            end

            // Scale magnitude by Q16.16 and halve for the trapezoid, round away from zero
            neg = trap_sum < 0;
            mag = neg ? 64'(-trap_sum) : 64'(trap_sum);
            hi = mag >> 32;
            lo = mag & 64'hFFFF_FFFF;
            hi_part = hi * scale;
            hi_part = hi_part << 15;
            lo_part = lo * scale;
            lo_part = (lo_part + 65'd65536) >> 17;
            val = hi_part + lo_part;
            res_sat = 1'b0;
            if (!neg && val > COEF_POS)
            begin
                val = COEF_POS;
                res_sat = 1'b1;
            end
            if (neg && val > COEF_NEG)
            begin
                val = COEF_NEG;
                res_sat = 1'b1;
            end
            r.coef = neg ? -val[47:0] : val[47:0];
            r.sat  = sat_seen | res_sat;
            expected_q.push_back(r);
            clear_trajectory();
        endfunction

        function void check_result(logic signed [COEF_W-1:0] coef, logic sat);
            coef_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result beat: coefficient=%0d saturated=%0b", coef, sat);
                fails++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (sat)
            begin
                saturated_seen++;
            end
            if (coef !== e.coef)
            begin
                $error("coefficient mismatch: expected %0d actual %0d", e.coef, coef);
                fails++;
            end
            if (sat !== e.sat)
            begin
                $error("saturated mismatch: expected %0b actual %0b", e.sat, sat);
                fails++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   settings;
    int   idle_cycles = 0;

    coef_scoreboard sb;

    cbtc_sample_if sample_ch ();
    cbtc_result_if result_ch ();
    cbtc_cfg_if    cfg_ch ();

    cosine_basis_trajectory_coefficient_core #(
        .COS_TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result ready: stall at random per the current phase
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Check result beats and watch for a hang; everything is stable at negedge
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && sb != null)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                sb.check_result(result_ch.coefficient, result_ch.saturated);
            end
            if ((result_ch.valid && result_ch.ready) || (sample_ch.valid && sample_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat accepted in %0d cycles", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // One sample beat; leaves valid high so back-to-back beats need no gap
    task automatic send_sample(bit [15:0] px, bit [15:0] pz, bit last);
        bit hit;
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.pos_x       <= px;
        sample_ch.pos_z       <= pz;
        sample_ch.last_sample <= last;
        do
        begin
            @(negedge clk);
            hit = sample_ch.ready;
            @(posedge clk);
        end
        while (!hit);
        sb.note_sample(px, pz, last);
    endtask

    // One register beat; caller drops valid after the last one
    task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        bit hit;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
        begin
            @(negedge clk);
            hit = cfg_ch.ready;
            @(posedge clk);
        end
        while (!hit);
        sb.write_reg(idx, data);
    endtask

    // Program all registers; upper bits of wave writes carry junk
    task automatic program_regs(bit [7:0] wx, bit [7:0] wz, bit [31:0] sc, bit junk);
        cfg_beat(REG_WAVE_X, {24'($urandom), wx});
        cfg_beat(REG_WAVE_Z, {24'($urandom), wz});
        if (junk)
        begin
            cfg_beat(REG_UNUSED, $urandom);
        end
        cfg_beat(REG_NORM_SCALE, sc);
        cfg_ch.valid <= 1'b0;
        settings++;
    endtask

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic bit [15:0] pick_pos();
        case ($urandom_range(0, 15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h4000;
            3:       return 16'h8000;
            4:       return 16'hC000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [7:0] pick_wave();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bit [31:0] pick_scale();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return SCALE_MAX;
            2:       return SCALE_ONE;
            3:       return 32'($urandom_range(0, 262143));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_trajectory(int len);
        for (int i = 0; i < len; i++)
        begin
            send_sample(pick_pos(), pick_pos(), i == len - 1);
        end
    endtask

    // Random trajectories over several register settings at one pacing
    task automatic random_phase(int src_pct, int sink_pct);
        int sent;
        int len;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int s = 0; s < SETS_PER_PHASE; s++)
        begin
            drain();
            program_regs(pick_wave(), pick_wave(), pick_scale(), $urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < ITEMS_PER_SET)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(1, 12);
                send_trajectory(len);
                sent += len;
            end
        end
        drain();
    endtask

    // Stimulus
    initial
    begin
        int ntraj;
        sb = new();
        settings       = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        rst_n                 <= 1'b0;
        sample_ch.valid       <= 1'b0;
        sample_ch.pos_x       <= '0;
        sample_ch.pos_z       <= '0;
        sample_ch.last_sample <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_WAVE_X;
        cfg_ch.data           <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: single-sample trajectory, then a short one at the extremes
        send_sample(16'h0000, 16'h0000, 1'b1);
        send_sample(16'hFFFF, 16'hFFFF, 1'b0);
        send_sample(16'h8000, 16'h4000, 1'b0);
        send_sample(16'h1234, 16'hFEDC, 1'b1);
        drain();

        // Top wave index, full scale, write to the unused index
        program_regs(8'd255, 8'd1, SCALE_MAX, 1'b1);
        send_sample(16'hFFFF, 16'h0000, 1'b0);
        send_sample(16'h3039, 16'hFFFF, 1'b0);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_sample(16'h4000, 16'hC000, 1'b1);
        drain();

        // Zero scale; phases at exactly a quarter and a half of a turn
        program_regs(8'd1, 8'd2, 32'd0, 1'b0);
        send_sample(16'h4000, 16'h4000, 1'b0);
        send_sample(16'hC000, 16'h8000, 1'b0);
        send_sample(16'hFFFF, 16'h0001, 1'b1);
        drain();

        program_regs(8'd3, 8'd5, SCALE_ONE, 1'b0);
        send_trajectory(5);
        drain();

        // Long positive trajectory at full scale: large sum, wide result
        program_regs(8'd0, 8'd0, SCALE_MAX, 1'b0);
        ntraj = 150;
        for (int i = 0; i < ntraj; i++)
        begin
            send_sample(16'($urandom), 16'($urandom), i == ntraj - 1);
        end
        drain();

        // Long negative trajectory at full scale: large negative result
        program_regs(8'd0, 8'd2, SCALE_MAX, 1'b0);
        ntraj = 100;
        for (int i = 0; i < ntraj; i++)
        begin
            send_sample(16'($urandom), 16'h8000, i == ntraj - 1);
        end
        drain();

        // Random trajectories under each pacing
        random_phase(0, 0);
        random_phase(IDLE_HEAVY, 0);
        random_phase(0, IDLE_HEAVY);
        random_phase(IDLE_LIGHT, IDLE_LIGHT);

        $display("run covered %0d samples, %0d coefficients checked (%0d saturated)",
                 sb.samples, sb.checked, sb.saturated_seen);
        $display("register settings: %0d, mismatches: %0d", settings, sb.fails);
        if (sb.fails == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/cbtc_pkg.sv
src/cbtc_sample_if.sv
src/cbtc_result_if.sv
src/cbtc_cfg_if.sv
src/cbtc_ctrl.sv
src/cbtc_dp.sv
src/cosine_basis_trajectory_coefficient_core.sv
tb/tb_cosine_basis_trajectory_coefficient_core.sv
